// File: src/rrbc_pkg.sv
// Shared types and constants for the ROM/RAM bank controller.
package rrbc_pkg;

  localparam int unsigned BankAddrW = 14;   // 16 KiB ROM bank
  localparam int unsigned BankW     = 4;
  localparam int unsigned RomAddrW  = BankW + BankAddrW;
  localparam int unsigned RamWinW   = 9;    // 0xA000-0xA1FF window offset

  localparam logic [15:0] RamCtlHi  = 16'h1FFF;
  localparam logic [15:0] BankCtlHi = 16'h3FFF;
  localparam logic [15:0] RomLo     = 16'h4000;
  localparam logic [15:0] RomHi     = 16'h7FFF;
  localparam logic [15:0] SysLo     = 16'h8000;
  localparam logic [15:0] RamLo     = 16'hA000;
  localparam logic [15:0] RamHi     = 16'hA1FF;
  localparam logic [15:0] SysHi     = 16'hBFFF;
  localparam logic [7:0]  OpenBus   = 8'hFF;
  localparam logic [7:0]  BankMask  = 8'h0F;
  localparam logic [BankW-1:0] BankReset = BankW'(1);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ACT_SYS_READ  = 3'd0,
    ACT_ROM_READ  = 3'd1,
    ACT_RAM_READ  = 3'd2,
    ACT_SYS_WRITE = 3'd3,
    ACT_IGNORED   = 3'd4
  } action_e;

  typedef struct packed {
    action_e               action;
    logic [RomAddrW-1:0]   rom_addr;
    logic                  ram_read;
    logic                  ram_write;
    logic                  ram_toggle;
    logic                  bank_load;
  } dec_t;

endpackage

// File: src/rrbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rrbc_decode.sv
// Address decode of one bus access against the current bank and enable state.
module rrbc_decode import rrbc_pkg::*; (
  input  op_e              op_i,
  input  logic [15:0]      addr_i,
  input  logic [BankW-1:0] rom_bank_i,
  input  logic             ram_en_i,
  output dec_t             dec_o
);

  logic in_rom;
  logic in_ram;
  logic in_sys;

  assign in_rom = (addr_i >= RomLo) && (addr_i <= RomHi);
  assign in_ram = (addr_i >= RamLo) && (addr_i <= RamHi);
  assign in_sys = (addr_i >= SysLo) && (addr_i <= SysHi);

  always_comb begin
    dec_o            = '0;
    dec_o.action     = ACT_IGNORED;
    unique case (op_i)
      OP_READ: begin
        if (in_rom) begin
          dec_o.action   = ACT_ROM_READ;
          dec_o.rom_addr = {rom_bank_i, addr_i[BankAddrW-1:0]};
        end else if (in_ram) begin
          dec_o.action   = ACT_RAM_READ;
          dec_o.ram_read = 1'b1;
        end else begin
          dec_o.action   = ACT_SYS_READ;
        end
      end
      OP_WRITE: begin
        if (addr_i <= RamCtlHi) begin
          dec_o.ram_toggle = !addr_i[8];
        end else if (addr_i <= BankCtlHi) begin
          dec_o.bank_load  = addr_i[8];
        end else if (in_ram) begin
          dec_o.ram_write  = ram_en_i;
        end else if (in_sys) begin
          dec_o.action     = ACT_SYS_WRITE;
        end
      end
      default: dec_o.action = ACT_IGNORED;
    endcase
  end

endmodule

// File: src/rom_ram_bank_controller.sv
// Result path: an accepted access goes through the decode stage, then the output register.
// Throughput: one access per cycle unless stalled; state updates at input accept, RAM read is registered.
// Reset: bank = 1, RAM disabled; then a clearing pass writes 0xFF to every RAM entry,
// one per cycle, with s_axis_tready low until it is done.
// Top level: ROM/RAM bank controller, bus access in, routing result out.
module rom_ram_bank_controller import rrbc_pkg::*; #(
  parameter int unsigned RAM_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [15:0] bus_address, [23:16] write_byte
  input  logic        s_axis_tuser_i,  // [0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [17:0] rom_byte_address, [25:18] read_byte, zero pad
  output logic [2:0]  m_axis_tuser_o   // [2:0] action
);

  localparam int unsigned AW       = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
  localparam int          ModSteps = RamWinW - $clog2(RAM_BYTES) + 1;

  logic [15:0] addr;
  logic [7:0]  wbyte;
  op_e         op;
  dec_t        dec;
  logic        accept;

  logic [BankW-1:0] rom_bank_q, rom_bank_d;
  logic             ram_en_q, ram_en_d;
  logic             clearing_q, clearing_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;

  logic [RamWinW-1:0] ram_off;
  logic [AW-1:0]      ram_idx;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;

  logic                s1_valid_q, s1_valid_d;
  action_e             s1_action_q;
  logic [RomAddrW-1:0] s1_rom_addr_q;
  logic                s1_ram_read_q;
  logic                s1_ram_en_q;

  logic                out_valid_q, out_valid_d;
  action_e             out_action_q;
  logic [RomAddrW-1:0] out_rom_addr_q;
  logic [7:0]          out_rbyte_q;
  logic [7:0]          s1_rbyte;

  logic out_adv;
  logic s1_adv;

  assign addr  = s_axis_tdata_i[15:0];
  assign wbyte = s_axis_tdata_i[23:16];
  assign op    = op_e'(s_axis_tuser_i);

  rrbc_decode u_decode (
    .op_i       (op),
    .addr_i     (addr),
    .rom_bank_i (rom_bank_q),
    .ram_en_i   (ram_en_q),
    .dec_o      (dec)
  );

  // window offset reduced modulo RAM_BYTES by shifted compare-subtract
  always_comb begin
    logic [RamWinW-1:0] rem;
    rem = RamWinW'(addr - RamLo);
    for (int k = ModSteps - 1; k >= 0; k--) begin
      if (32'(rem) >= (32'(RAM_BYTES) << k)) begin
        rem = rem - RamWinW'(32'(RAM_BYTES) << k);
      end
    end
    ram_off = rem;
  end

  assign ram_idx = AW'(ram_off);

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = !s1_valid_q || out_adv;
  assign s_axis_tready_o = !clearing_q && s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // control state
  always_comb begin
    rom_bank_d  = rom_bank_q;
    ram_en_d    = ram_en_q;
    clearing_d  = clearing_q;
    clr_cnt_d   = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(RAM_BYTES - 1)) begin
        clearing_d = 1'b0;
      end
    end
    if (accept && dec.ram_toggle) begin
      ram_en_d = !ram_en_q;
    end
    if (accept && dec.bank_load) begin
      rom_bank_d = BankW'(wbyte & BankMask);
    end
  end

  assign ram_we    = clearing_q || (accept && dec.ram_write);
  assign ram_waddr = clearing_q ? clr_cnt_q : ram_idx;
  assign ram_wdata = clearing_q ? OpenBus : wbyte;

  rrbc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (ram_idx),
    .rdata_o (ram_rdata)
  );

  assign s1_valid_d  = s1_adv ? accept : s1_valid_q;
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  always_comb begin
    s1_rbyte = '0;
    if (s1_ram_read_q) begin
      s1_rbyte = s1_ram_en_q ? ram_rdata : OpenBus;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q  <= BankReset;
      ram_en_q    <= 1'b0;
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rom_bank_q  <= rom_bank_d;
      ram_en_q    <= ram_en_d;
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q   <= dec.action;
      s1_rom_addr_q <= dec.rom_addr;
      s1_ram_read_q <= dec.ram_read;
      s1_ram_en_q   <= ram_en_q;
    end
    if (out_adv && s1_valid_q) begin
      out_action_q   <= s1_action_q;
      out_rom_addr_q <= s1_rom_addr_q;
      out_rbyte_q    <= s1_rbyte;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_rbyte_q, out_rom_addr_q};
  assign m_axis_tuser_o  = out_action_q;

endmodule

// File: tb/sv/rrbc_checker.sv
// Checker for the bank controller: predicts the routing of every access and compares results.
module rrbc_checker import rrbc_pkg::*; #(
  parameter int unsigned RAM_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [23:0] s_axis_tdata_i,  // [15:0] bus_address, [23:16] write_byte
  input  logic        s_axis_tuser_i,  // [0] operation
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,  // [17:0] rom_byte_address, [25:18] read_byte
  input  logic [2:0]  m_axis_tuser_i,  // [2:0] action
  output int          mismatch_cnt_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    action_e             act;
    logic [RomAddrW-1:0] rom_addr;
    logic [7:0]          rd_byte;
  } routing_t;

  logic [BankW-1:0] bank_q;
  logic             ram_en_q;
  logic [7:0]       ram_q [RAM_BYTES];
  routing_t         routing_q [$];

  // Updates the predicted controller state and returns the routing of one access.
  function automatic routing_t route_access(op_e op, logic [15:0] addr, logic [7:0] wbyte);
    routing_t    r;
    int unsigned idx;
    logic        bit8;
    r.act      = ACT_SYS_READ;
    r.rom_addr = '0;
    r.rd_byte  = '0;
    bit8       = addr[8];
    idx        = (32'(addr) - 32'(RamLo)) % RAM_BYTES;
    if (op == OP_READ) begin
      if (addr >= RomLo && addr <= RomHi) begin
        r.act      = ACT_ROM_READ;
        r.rom_addr = RomAddrW'(32'(bank_q) * 32'h4000 + 32'(addr - RomLo));
      end else if (addr >= RamLo && addr <= RamHi) begin
        r.act     = ACT_RAM_READ;
        r.rd_byte = ram_en_q ? ram_q[idx] : OpenBus;
      end
    end else begin
      r.act = ACT_IGNORED;
      if (addr <= RamCtlHi) begin
        if (!bit8) begin
          ram_en_q = !ram_en_q;
        end
      end else if (addr <= BankCtlHi) begin
        if (bit8) begin
          bank_q = BankW'(wbyte & BankMask);
        end
      end else if (addr >= RamLo && addr <= RamHi) begin
        if (ram_en_q) begin
          ram_q[idx] = wbyte;
        end
      end else if (addr >= SysLo && addr <= SysHi) begin
        r.act = ACT_SYS_WRITE;
      end
    end
    return r;
  endfunction

  // Results leave only after the decode and output registers, so a result seen at the same
  // edge as an input transaction always belongs to an earlier access.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    routing_t exp_r;
    if (!rst_ni) begin
      bank_q   = BankReset;
      ram_en_q = 1'b0;
      for (int i = 0; i < RAM_BYTES; i++) begin
        ram_q[i] = 8'hFF;
      end
      routing_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (routing_q.size() == 0) begin
          $error("unexpected result transaction: action %0d", m_axis_tuser_i);
          mismatch_cnt_o++;
        end else begin
          exp_r = routing_q.pop_front();
          if (m_axis_tuser_i !== exp_r.act) begin
            $error("action: expected %0d, actual %0d", exp_r.act, m_axis_tuser_i);
            mismatch_cnt_o++;
          end
          if (m_axis_tdata_i[17:0] !== exp_r.rom_addr) begin
            $error("rom_byte_address: expected 0x%05h, actual 0x%05h",
                   exp_r.rom_addr, m_axis_tdata_i[17:0]);
            mismatch_cnt_o++;
          end
          if (m_axis_tdata_i[25:18] !== exp_r.rd_byte) begin
            $error("read_byte: expected 0x%02h, actual 0x%02h",
                   exp_r.rd_byte, m_axis_tdata_i[25:18]);
            mismatch_cnt_o++;
          end
          if (m_axis_tdata_i[31:26] !== 6'd0) begin
            $error("tdata padding: expected 0x00, actual 0x%02h", m_axis_tdata_i[31:26]);
            mismatch_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        routing_q.push_back(route_access(op_e'(s_axis_tuser_i), s_axis_tdata_i[15:0],
                                         s_axis_tdata_i[23:16]));
      end
    end
    pending_o = routing_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the bank controller: clock, reset, bus access stimulus and verdict.
module tb_top import rrbc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RamBytes     = 512;
  localparam int          ItemsPerPass = 213;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata  = '0;   // [15:0] bus_address, [23:16] write_byte
  logic        s_axis_tuser  = 1'b0; // [0] operation
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;         // [17:0] rom_byte_address, [25:18] read_byte, zero pad
  logic [2:0]  m_axis_tuser;         // [2:0] action
  int          mismatch_cnt;
  int          pending;
  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;

  rom_ram_bank_controller #(.RAM_BYTES(RamBytes)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  rrbc_checker #(.RAM_BYTES(RamBytes)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_o       (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Drives one access and returns at the falling edge after its transaction.
  task automatic send_access(input op_e op, input logic [15:0] addr, input logic [7:0] wbyte);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wbyte, addr};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly accesses that hit a decoded window, the rest anywhere in the map.
  task automatic send_random_access();
    op_e         op;
    logic [15:0] addr;
    logic [7:0]  wbyte;
    int unsigned pick;
    pick  = $urandom_range(99);
    op    = op_e'($urandom_range(1));
    addr  = 16'($urandom);
    wbyte = 8'($urandom);
    if (pick < 20) begin
      op   = OP_READ;
      addr = RomLo + 16'($urandom_range(16'h3FFF));
    end else if (pick < 42) begin
      addr = RamLo + 16'($urandom_range(RamBytes - 1));
    end else if (pick < 52) begin
      op      = OP_WRITE;
      addr    = 16'($urandom_range(RamCtlHi));
      addr[8] = ($urandom_range(3) == 0);
    end else if (pick < 60) begin
      op      = OP_WRITE;
      addr    = 16'h2000 + 16'($urandom_range(16'h1FFF));
      addr[8] = ($urandom_range(3) != 0);
    end
    send_access(op, addr, wbyte);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners: window edges, disabled RAM, enable toggle, bank 0 and 15
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'hFFFF, 8'hFF);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'hA000, 8'h12);
    send_access(OP_WRITE, 16'h1EFF, 8'hFF);
    send_access(OP_WRITE, 16'h0100, 8'h0A);
    send_access(OP_WRITE, 16'hA1FF, 8'h5A);
    send_access(OP_READ,  16'hA1FF, 8'h00);
    send_access(OP_READ,  16'h9800, 8'h00);
    send_access(OP_WRITE, 16'h2100, 8'hFF);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h3FFF, 8'h00);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h03);
    send_access(OP_WRITE, 16'h8000, 8'h77);
    send_access(OP_WRITE, 16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h4000, 8'h11);
    send_access(OP_WRITE, 16'hFFFF, 8'hFF);
    send_access(OP_WRITE, 16'h9FFF, 8'h01);
    send_access(OP_WRITE, 16'h0000, 8'h00);
    send_access(OP_READ,  16'hA1FF, 8'h00);
    send_access(OP_WRITE, 16'hA200, 8'h00);
    send_access(OP_READ,  16'hA200, 8'h00);

    // flow control passes: none, sender idle, receiver stalled, both
    for (int pass = 0; pass < 4; pass++) begin
      src_idle_pct  = (pass == 1) ? 88 : (pass == 3) ? 29 : 0;
      snk_stall_pct = (pass == 2) ? 88 : (pass == 3) ? 29 : 0;
      repeat (ItemsPerPass) send_random_access();
    end
    s_axis_tvalid <= 1'b0;
    snk_stall_pct = 0;

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
src/rrbc_pkg.sv
src/rrbc_ram.sv
src/rrbc_decode.sv
src/rom_ram_bank_controller.sv
tb/sv/rrbc_checker.sv
tb/sv/tb_top.sv
